// File: sv/sfla_pkg.sv
// ----------------------------------------------------------------------------
// sfla_pkg
// shared types and constants of the segregated free-list allocator
// ----------------------------------------------------------------------------
package sfla_pkg;

  localparam int AlignBytes     = 8;
  localparam int MaxSmallBytes  = 128;
  localparam int NodesPerRefill = 20;
  localparam int ArenaBytes     = 65536;
  localparam int NumLists       = MaxSmallBytes / AlignBytes;
  localparam int ClsW           = $clog2(NumLists);
  localparam int NodeW          = 13;
  localparam int NodeDepth      = 1 << NodeW;
  localparam int CntW           = $clog2(NodesPerRefill + 1);

  localparam logic       REQ_ALLOC = 1'b0;
  localparam logic       REQ_FREE  = 1'b1;
  localparam logic [1:0] ST_ALLOC  = 2'd0;
  localparam logic [1:0] ST_FREED  = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;
  localparam logic [1:0] ST_OOM    = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [NodeW-1:0] idx;
  } link_t;

  typedef enum logic [3:0] {
    S_IDLE, S_POP_RD, S_POP_WB, S_TAKE, S_PUSH, S_ARENA, S_SCAN,
    S_SCAN_WB, S_LINK, S_DONE
  } state_t;

endpackage

// File: sv/segregated_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// segregated_free_list_allocator_top
// small-block allocator with sixteen size-class free lists over a fixed arena
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  request | req_valid req_ready req_type         | in
//          | req_bytes block_addr                 |
//  result  | rsp_valid rsp_ready result_addr      | out
//          | status                               |
// a bad size goes straight to the result, a free pushes onto its list and a pop
// takes the list head; an empty list is refilled with up to NodesPerRefill blocks
// from the chunk; a spent chunk takes new arena space, else scans the lists
// the result register holds one beat, so a waiting result stalls only the hand-off
// reset empties all lists and the arena; node memory is not cleared
module segregated_free_list_allocator_top
  import sfla_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        req_type,
  input  logic [7:0]  req_bytes,
  input  logic [15:0] block_addr,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [15:0] result_addr,
  output logic [1:0]  status
);

  link_t            node_mem [NodeDepth];
  link_t            rd_data;
  logic [NodeW-1:0] rd_addr;
  logic             wr_en;
  logic [NodeW-1:0] wr_addr;
  link_t            wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_mem[wr_addr] <= wr_data;
    end
    rd_data <= node_mem[rd_addr];
  end

  link_t           head [NumLists];
  state_t          state, state_next;
  logic [8:0]      size;
  logic [ClsW-1:0] cls, scls;
  logic [16:0]     cstart, cend, obtained, atop;
  logic [CntW-1:0] k;
  logic [16:0]     laddr;
  logic [15:0]     raddr, oaddr;
  logic [1:0]      rstat, ostat;
  logic            pend;

  logic            bad, fits, more, last, arena_ok, hand_off;
  logic [16:0]     left, total, want, nxt1, cand;
  logic [ClsW-1:0] lcls;

  assign bad      = (req_bytes == 8'd0) || (9'(req_bytes) > 9'(MaxSmallBytes));
  assign left     = cend - cstart;
  assign fits     = left >= 17'(size);
  assign total    = 17'(size) * 17'(NodesPerRefill);
  assign want     = (total << 1) + (((obtained >> 4) + 17'd7) & ~17'd7);
  assign arena_ok = (18'(atop) + 18'(want)) <= 18'(ArenaBytes);
  assign nxt1     = cstart + 17'(size);
  assign cand     = laddr + 17'(size);
  assign more     = (NodesPerRefill > 1) && (nxt1 + 17'(size) <= cend);
  assign last     = (k == CntW'(NodesPerRefill - 1)) || (cand + 17'(size) > cend);
  assign lcls     = ClsW'((left + 17'd7) >> 3) - ClsW'(1);
  assign hand_off = (state == S_DONE) && (!pend || rsp_ready);

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = pend;
  assign result_addr = oaddr;
  assign status = ostat;

  always_comb begin
    state_next = state;
    rd_addr = head[cls].idx;
    wr_en = 1'b0;
    wr_addr = laddr[15:3];
    wr_data = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (bad) state_next = S_DONE;
          else if (req_type == REQ_FREE) state_next = S_PUSH;
          else state_next = S_POP_RD;
        end
      end
      S_POP_RD: state_next = S_POP_WB;
      S_POP_WB: state_next = head[cls].valid ? S_DONE : S_TAKE;
      S_TAKE: begin
        if (fits) begin
          state_next = more ? S_LINK : S_DONE;
        end else begin
          state_next = S_ARENA;
          if (left != '0) begin
            wr_en = 1'b1;
            wr_addr = cstart[15:3];
            wr_data = head[lcls];
          end
        end
      end
      S_PUSH: begin
        wr_en = 1'b1;
        wr_data = head[cls];
        state_next = S_DONE;
      end
      S_ARENA: state_next = arena_ok ? S_TAKE : S_SCAN;
      S_SCAN: begin
        rd_addr = head[scls].idx;
        if (head[scls].valid) state_next = S_SCAN_WB;
        else if (scls == ClsW'(NumLists - 1)) state_next = S_DONE;
      end
      S_SCAN_WB: state_next = S_TAKE;
      S_LINK: begin
        wr_en = 1'b1;
        wr_data.valid = !last;
        wr_data.idx = last ? '0 : cand[15:3];
        if (last) state_next = S_DONE;
      end
      S_DONE: begin
        if (hand_off) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      oaddr <= '0;
      ostat <= ST_ALLOC;
      cstart <= '0;
      cend <= '0;
      obtained <= '0;
      atop <= '0;
      for (int i = 0; i < NumLists; i++) head[i] <= '0;
    end else begin
      if (hand_off) begin
        pend <= 1'b1;
        oaddr <= raddr;
        ostat <= rstat;
      end else if (rsp_ready) begin
        pend <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            size <= {1'b0, req_bytes[7:3], 3'b0} + {5'b0, |req_bytes[2:0], 3'b0};
            cls <= ClsW'((9'(req_bytes) + 9'd7) >> 3) - ClsW'(1);
            laddr <= {1'b0, block_addr[15:3], 3'b0};
            raddr <= '0;
            if (bad) rstat <= ST_BAD;
            else if (req_type == REQ_FREE) rstat <= ST_FREED;
            else rstat <= ST_ALLOC;
          end
        end
        S_POP_WB: begin
          if (head[cls].valid) begin
            raddr <= {head[cls].idx, 3'b0};
            head[cls] <= rd_data;
          end
        end
        S_TAKE: begin
          if (fits) begin
            raddr <= cstart[15:0];
            cstart <= nxt1;
            if (more) begin
              head[cls] <= '{1'b1, nxt1[15:3]};
              laddr <= nxt1;
              k <= CntW'(1);
            end
          end else if (left != '0) begin
            head[lcls] <= '{1'b1, cstart[15:3]};
          end
        end
        S_PUSH: head[cls] <= '{1'b1, laddr[15:3]};
        S_ARENA: begin
          if (arena_ok) begin
            cstart <= atop;
            cend <= atop + want;
            atop <= atop + want;
            obtained <= obtained + want;
          end else begin
            scls <= cls;
          end
        end
        S_SCAN: begin
          if (!head[scls].valid) begin
            if (scls == ClsW'(NumLists - 1)) begin
              cstart <= '0;
              cend <= '0;
              raddr <= '0;
              rstat <= ST_OOM;
            end else begin
              scls <= scls + ClsW'(1);
            end
          end
        end
        S_SCAN_WB: begin
          cstart <= {1'b0, head[scls].idx, 3'b0};
          cend <= {1'b0, head[scls].idx, 3'b0} + ((17'(scls) + 17'd1) << 3);
          head[scls] <= rd_data;
        end
        S_LINK: begin
          k <= k + CntW'(1);
          laddr <= cand;
          cstart <= cand;
        end
        default: ;
      endcase
    end
  end

endmodule
